// ===== design/rqdd_pkg.sv =====
`default_nettype none
package rqdd_pkg;

  localparam int QUEUE_BITS    = 20;
  localparam int FRAC_BITS     = 16;
  localparam int IDLE_EXP_BITS = 16;
  localparam int AVG_BITS      = QUEUE_BITS + FRAC_BITS;
  localparam int PROB_BITS     = FRAC_BITS + 1;
  localparam int PROD_BITS     = AVG_BITS + PROB_BITS;
  localparam int TIME_BITS     = 32;
  localparam int TAG_BITS      = 32;
  localparam int CNT_BITS      = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (QUEUE_BITS > PROB_BITS) ? QUEUE_BITS : PROB_BITS;
  localparam int QCNT_BITS     = $clog2(PROB_BITS);

  localparam logic [PROB_BITS-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_NOTICE  = 1'b1;

  localparam logic VERDICT_PASS = 1'b0;
  localparam logic VERDICT_DROP = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_TH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TH  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_P_MIN   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_P_MAX   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EW_A,
    ST_EW_B,
    ST_EW_SUM,
    ST_DC_R,
    ST_DC_B,
    ST_DC_BW,
    ST_DC_AVG,
    ST_DC_AVGW,
    ST_PR_CMP,
    ST_PR_MULW,
    ST_PR_DIV,
    ST_PR_FIX,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [AVG_BITS-1:0]  a;
    logic [PROB_BITS-1:0] b;
  } mul_op_t;

  function automatic logic [PROB_BITS-1:0] sat_one(input logic [PROB_BITS-1:0] v);
    sat_one = (v > ONE_FX) ? ONE_FX : v;
  endfunction

endpackage
`default_nettype wire

// ===== design/red_queue_drop_decider.sv =====
// Notice (mode 1): taken without leaving the idle state, no result.
// Arrival (mode 0): the average is updated as a weighted mean on a non-empty queue, or
// decayed by square-and-multiply rounds on the one shared multiplier on an empty queue;
// inside the open threshold band the probability is interpolated (17-step divide).
// No new request is taken until the result is in the output register. Synchronous reset
// clears state, configuration, queue state, average, drop count and out_valid.
`default_nettype none
module red_queue_drop_decider import rqdd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic                     mode,
  input  wire logic [TIME_BITS-1:0]     now_ms,
  input  wire logic [QUEUE_BITS-1:0]    queue_length,
  input  wire logic [FRAC_BITS-1:0]     random_value,
  input  wire logic [TAG_BITS-1:0]      packet_tag,
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic                     verdict,
  output      logic [TAG_BITS-1:0]      tag_out,
  output      logic [PROB_BITS-1:0]     probability_out,
  output      logic [AVG_BITS-1:0]      average_out,
  output      logic [CNT_BITS-1:0]      drops_so_far
);

  state_t state, state_next;

  logic [QUEUE_BITS-1:0]    min_th, max_th;
  logic [PROB_BITS-1:0]     p_min, p_max, weight;
  logic [QUEUE_BITS-1:0]    last_q;
  logic [TIME_BITS-1:0]     empty_since;
  logic [AVG_BITS-1:0]      avg;
  logic [PROB_BITS-1:0]     prob;
  logic [CNT_BITS-1:0]      drop_counter;

  logic [FRAC_BITS-1:0]     rnd;
  logic [TAG_BITS-1:0]      tag;
  logic [IDLE_EXP_BITS-1:0] idle;
  logic [PROB_BITS-1:0]     r_fx, b_fx;
  logic [PROD_BITS-1:0]     acc;
  logic [AVG_BITS-1:0]      rem, den;
  logic [PROB_BITS-1:0]     quot, num_lo, diff;
  logic [QCNT_BITS-1:0]     qcnt;
  logic                     p_up;

  mul_op_t                  mul_op;
  logic [PROD_BITS-1:0]     prod;

  logic                     in_acc, out_load, drop_now;
  logic [PROB_BITS-1:0]     w, w_inv, pmin_s, pmax_s, diff_c, prob_sel;
  logic [AVG_BITS-1:0]      minf, maxf, qf;
  logic [TIME_BITS-1:0]     elapsed;
  logic [IDLE_EXP_BITS-1:0] idle_sat, idle_shift;
  logic [PROD_BITS-1:0]     ew_sum;
  logic                     in_band;
  logic [AVG_BITS:0]        trial, trial_sub;
  logic                     ge;
  logic [CNT_BITS-1:0]      drops_next;

  rqdd_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  assign w        = sat_one(weight);
  assign w_inv    = ONE_FX - w;
  assign pmin_s   = sat_one(p_min);
  assign pmax_s   = sat_one(p_max);
  assign diff_c   = (pmax_s >= pmin_s) ? (pmax_s - pmin_s) : (pmin_s - pmax_s);
  assign minf     = {min_th, {FRAC_BITS{1'b0}}};
  assign maxf     = {max_th, {FRAC_BITS{1'b0}}};
  assign qf       = {last_q, {FRAC_BITS{1'b0}}};
  assign elapsed  = now_ms - empty_since;
  assign idle_sat = (|elapsed[TIME_BITS-1:IDLE_EXP_BITS]) ? {IDLE_EXP_BITS{1'b1}}
                                                          : elapsed[IDLE_EXP_BITS-1:0];
  assign idle_shift = idle >> 1;
  assign ew_sum   = acc + prod;
  assign in_band  = (avg > minf) && (avg < maxf);
  assign trial    = {rem, num_lo[PROB_BITS-1]};
  assign trial_sub = trial - {1'b0, den};
  assign ge       = (trial >= {1'b0, den});

  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == ST_FINISH) && (!out_valid || !out_stall);
  assign drop_now = ({1'b0, rnd} < prob);
  assign drops_next = drop_counter + CNT_BITS'(drop_now);

  always_comb begin
    priority if (avg > maxf) begin
      prob_sel = ONE_FX;
    end else if (avg == maxf) begin
      prob_sel = pmax_s;
    end else if (avg == minf) begin
      prob_sel = pmin_s;
    end else begin
      prob_sel = '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (mode == MODE_ARRIVAL)) begin
          priority if (last_q != '0) begin
            state_next = ST_EW_A;
          end else if (idle_sat == '0) begin
            state_next = ST_DC_AVG;
          end else if (idle_sat[0]) begin
            state_next = ST_DC_R;
          end else begin
            state_next = ST_DC_B;
          end
        end
      end
      ST_EW_A:    state_next = ST_EW_B;
      ST_EW_B:    state_next = ST_EW_SUM;
      ST_EW_SUM:  state_next = ST_PR_CMP;
      ST_DC_R:    state_next = ST_DC_B;
      ST_DC_B:    state_next = (idle_shift == '0) ? ST_DC_AVG : ST_DC_BW;
      ST_DC_BW:   state_next = idle_shift[0] ? ST_DC_R : ST_DC_B;
      ST_DC_AVG:  state_next = ST_DC_AVGW;
      ST_DC_AVGW: state_next = ST_PR_CMP;
      ST_PR_CMP:  state_next = in_band ? ST_PR_MULW : ST_FINISH;
      ST_PR_MULW: state_next = ST_PR_DIV;
      ST_PR_DIV:  state_next = (qcnt == '0) ? ST_PR_FIX : ST_PR_DIV;
      ST_PR_FIX:  state_next = ST_FINISH;
      ST_FINISH:  state_next = out_load ? ST_IDLE : ST_FINISH;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    mul_op   = '0;
    unique case (state)
      ST_EW_A: begin
        mul_op.a = avg;
        mul_op.b = w_inv;
      end
      ST_EW_B: begin
        mul_op.a = qf;
        mul_op.b = w;
      end
      ST_DC_R: begin
        mul_op.a = AVG_BITS'(r_fx);
        mul_op.b = b_fx;
      end
      ST_DC_B: begin
        mul_op.a = AVG_BITS'(b_fx);
        mul_op.b = b_fx;
      end
      ST_DC_AVG: begin
        mul_op.a = avg;
        mul_op.b = r_fx;
      end
      ST_PR_CMP: begin
        mul_op.a = avg - minf;
        mul_op.b = diff_c;
      end
      default: begin
        mul_op = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_th <= '0;
      max_th <= '0;
      p_min  <= '0;
      p_max  <= '0;
      weight <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_TH: min_th <= cfg_data[QUEUE_BITS-1:0];
        REG_MAX_TH: max_th <= cfg_data[QUEUE_BITS-1:0];
        REG_P_MIN:  p_min  <= cfg_data[PROB_BITS-1:0];
        REG_P_MAX:  p_max  <= cfg_data[PROB_BITS-1:0];
        REG_WEIGHT: weight <= cfg_data[PROB_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_q       <= '0;
      empty_since  <= '0;
      avg          <= '0;
      prob         <= '0;
      drop_counter <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (mode == MODE_NOTICE)) begin
            last_q <= queue_length;
            if (queue_length == '0) begin
              empty_since <= now_ms;
            end
          end
        end
        ST_EW_SUM:  avg <= ew_sum[FRAC_BITS +: AVG_BITS];
        ST_DC_AVGW: avg <= prod[FRAC_BITS +: AVG_BITS];
        ST_PR_CMP: begin
          if (!in_band) begin
            prob <= prob_sel;
          end
        end
        ST_PR_FIX:  prob <= p_up ? (pmin_s + quot) : (pmin_s - quot);
        ST_FINISH: begin
          if (out_load) begin
            drop_counter <= drops_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          rnd  <= random_value;
          tag  <= packet_tag;
          r_fx <= ONE_FX;
          b_fx <= w_inv;
          idle <= idle_sat;
        end
      end
      ST_EW_B: acc <= prod;
      ST_DC_B: begin
        if (idle[0]) begin
          r_fx <= prod[FRAC_BITS +: PROB_BITS];
        end
      end
      ST_DC_BW: begin
        b_fx <= prod[FRAC_BITS +: PROB_BITS];
        idle <= idle_shift;
      end
      ST_PR_CMP: begin
        den  <= maxf - minf;
        diff <= diff_c;
        p_up <= (pmax_s >= pmin_s);
      end
      ST_PR_MULW: begin
        rem    <= prod[PROD_BITS-1 -: AVG_BITS];
        num_lo <= prod[PROB_BITS-1:0];
        quot   <= '0;
        qcnt   <= QCNT_BITS'(PROB_BITS - 1);
      end
      ST_PR_DIV: begin
        rem    <= ge ? trial_sub[AVG_BITS-1:0] : trial[AVG_BITS-1:0];
        quot   <= {quot[PROB_BITS-2:0], ge};
        num_lo <= num_lo << 1;
        qcnt   <= qcnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict         <= drop_now ? VERDICT_DROP : VERDICT_PASS;
      tag_out         <= tag;
      probability_out <= prob;
      average_out     <= avg;
      drops_so_far    <= drops_next;
    end
  end

  a_div_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PR_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

  a_quot_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PR_FIX) |-> (quot <= diff))
    else $error("interpolation step exceeds probability span");

  a_decay_no_growth: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DC_AVGW) |=> (avg <= $past(avg)))
    else $error("idle decay raised the average");

  a_drop_count_step: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (drop_counter == $past(drop_counter) + CNT_BITS'(verdict)))
    else $error("drop count does not follow verdict");

  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (probability_out <= ONE_FX))
    else $error("probability above one");

endmodule
`default_nettype wire

// ===== design/rqdd_mul.sv =====
`default_nettype none
module rqdd_mul import rqdd_pkg::*; (
  input  wire logic                 clk,
  input  wire mul_op_t              op,
  output      logic [PROD_BITS-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op.a * op.b;
  end

endmodule
`default_nettype wire

// ===== tb/red_queue_drop_decider_tb.sv =====
`default_nettype none
module red_queue_drop_decider_tb;
  import rqdd_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 170;
  localparam logic [63:0] IDLE_MAX = (64'd1 << IDLE_EXP_BITS) - 64'd1;

  typedef enum int {
    PH_RISING,
    PH_FALLING,
    PH_CROSSED,
    PH_EQUAL,
    PH_FULL_SPAN,
    PH_OVERSIZED,
    PH_SLOW_WEIGHT,
    PH_HIGH_QUEUE
  } phase_kind_t;

  typedef struct packed {
    logic                 dropped;
    logic [TAG_BITS-1:0]  tag;
    logic [PROB_BITS-1:0] prob;
    logic [AVG_BITS-1:0]  avg;
    logic [CNT_BITS-1:0]  drops;
  } judgment_t;

  class drop_verdict_board;
    logic [QUEUE_BITS-1:0] min_th   = '0;
    logic [QUEUE_BITS-1:0] max_th   = '0;
    logic [PROB_BITS-1:0]  p_at_min = '0;
    logic [PROB_BITS-1:0]  p_at_max = '0;
    logic [PROB_BITS-1:0]  weight   = '0;
    logic [QUEUE_BITS-1:0] queue_len = '0;
    logic [TIME_BITS-1:0]  empty_ms  = '0;
    logic [AVG_BITS-1:0]   avg_q     = '0;
    logic [PROB_BITS-1:0]  prob      = '0;
    logic [CNT_BITS-1:0]   drop_cnt  = '0;
    judgment_t             pending_verdicts[$];
    int                    bad_results = 0;

    function void set_register(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        REG_MIN_TH: min_th   = value[QUEUE_BITS-1:0];
        REG_MAX_TH: max_th   = value[QUEUE_BITS-1:0];
        REG_P_MIN:  p_at_min = value[PROB_BITS-1:0];
        REG_P_MAX:  p_at_max = value[PROB_BITS-1:0];
        REG_WEIGHT: weight   = value[PROB_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(input logic md, input logic [TIME_BITS-1:0] t,
                               input logic [QUEUE_BITS-1:0] q,
                               input logic [FRAC_BITS-1:0] rv,
                               input logic [TAG_BITS-1:0] tag);
      logic [63:0] one, w, base, r, span, minf, maxf, lo, hi, a, p;
      logic [TIME_BITS-1:0] idle_ms;
      logic drop;
      judgment_t want;
      if (md == MODE_NOTICE) begin
        queue_len = q;
        if (q == '0) empty_ms = t;
        return;
      end
      one = 64'(ONE_FX);
      w = (weight > ONE_FX) ? one : 64'(weight);
      if (queue_len != '0) begin
        a = ((one - w) * 64'(avg_q) + w * (64'(queue_len) << FRAC_BITS)) >> FRAC_BITS;
      end else begin
        idle_ms = t - empty_ms;
        span = (64'(idle_ms) > IDLE_MAX) ? IDLE_MAX : 64'(idle_ms);
        base = one - w;
        r = one;
        for (int i = 0; i < IDLE_EXP_BITS; i++) begin
          if (span[i]) r = (r * base) >> FRAC_BITS;
          base = (base * base) >> FRAC_BITS;
        end
        a = (64'(avg_q) * r) >> FRAC_BITS;
      end
      avg_q = a[AVG_BITS-1:0];
      a = 64'(avg_q);
      minf = 64'(min_th) << FRAC_BITS;
      maxf = 64'(max_th) << FRAC_BITS;
      lo = (p_at_min > ONE_FX) ? one : 64'(p_at_min);
      hi = (p_at_max > ONE_FX) ? one : 64'(p_at_max);
      if (a < minf) prob = '0;
      if (a == minf) prob = lo[PROB_BITS-1:0];
      if (a == maxf) prob = hi[PROB_BITS-1:0];
      if (a > maxf) prob = ONE_FX;
      if (a > minf && a < maxf) begin
        if (hi >= lo) p = lo + ((hi - lo) * (a - minf)) / (maxf - minf);
        else p = lo - ((lo - hi) * (a - minf)) / (maxf - minf);
        prob = p[PROB_BITS-1:0];
      end
      drop = {1'b0, rv} < prob;
      if (drop) drop_cnt = drop_cnt + 1'b1;
      want.dropped = drop ? VERDICT_DROP : VERDICT_PASS;
      want.tag     = tag;
      want.prob    = prob;
      want.avg     = avg_q;
      want.drops   = drop_cnt;
      pending_verdicts.push_back(want);
    endfunction

    function void check_verdict(input logic v, input logic [TAG_BITS-1:0] tag,
                                input logic [PROB_BITS-1:0] p,
                                input logic [AVG_BITS-1:0] a,
                                input logic [CNT_BITS-1:0] d);
      judgment_t want;
      if (pending_verdicts.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected verdict: verdict %0d tag %h prob %0d avg %h drops %0d",
                   v, tag, p, a, d);
        return;
      end
      want = pending_verdicts.pop_front();
      if (want.dropped !== v || want.tag !== tag || want.prob !== p ||
          want.avg !== a || want.drops !== d) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("mismatch: expected verdict %0d tag %h prob %0d avg %h drops %0d",
                   want.dropped, want.tag, want.prob, want.avg, want.drops);
          $display("          actual   verdict %0d tag %h prob %0d avg %h drops %0d",
                   v, tag, p, a, d);
        end
      end
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    function bit passed();
      return bad_results == 0 && pending_verdicts.size() == 0;
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     mode = MODE_NOTICE;
  logic [TIME_BITS-1:0]     now_ms = '0;
  logic [QUEUE_BITS-1:0]    queue_length = '0;
  logic [FRAC_BITS-1:0]     random_value = '0;
  logic [TAG_BITS-1:0]      packet_tag = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     verdict;
  logic [TAG_BITS-1:0]      tag_out;
  logic [PROB_BITS-1:0]     probability_out;
  logic [AVG_BITS-1:0]      average_out;
  logic [CNT_BITS-1:0]      drops_so_far;

  drop_verdict_board    board;
  logic [TIME_BITS-1:0] wall_ms = '0;
  bit                   tx_idle_on = 1'b1;
  bit                   rx_idle_on = 1'b1;
  bit                   long_hold_req = 1'b0;
  int                   cycle_count = 0;

  red_queue_drop_decider i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** red_queue_drop_decider: FAILED **");
      $finish;
    end
  end

  task automatic send_request(input logic md, input logic [TIME_BITS-1:0] t,
                              input logic [QUEUE_BITS-1:0] q,
                              input logic [FRAC_BITS-1:0] rv,
                              input logic [TAG_BITS-1:0] tag);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= md;
    now_ms       <= t;
    queue_length <= q;
    random_value <= rv;
    packet_tag   <= tag;
    do @(posedge clk); while (in_stall);
    board.note_request(md, t, q, rv, tag);
  endtask

  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [QUEUE_BITS-1:0] lo_th,
                              input logic [QUEUE_BITS-1:0] hi_th,
                              input logic [PROB_BITS-1:0] pl,
                              input logic [PROB_BITS-1:0] ph,
                              input logic [PROB_BITS-1:0] w);
    logic [CFG_IDX_BITS-1:0]  reg_ids [5];
    logic [CFG_DATA_BITS-1:0] vals [5];
    reg_ids[0] = REG_MIN_TH; vals[0] = CFG_DATA_BITS'(lo_th);
    reg_ids[1] = REG_MAX_TH; vals[1] = CFG_DATA_BITS'(hi_th);
    reg_ids[2] = REG_P_MIN;  vals[2] = CFG_DATA_BITS'(pl);
    reg_ids[3] = REG_P_MAX;  vals[3] = CFG_DATA_BITS'(ph);
    reg_ids[4] = REG_WEIGHT; vals[4] = CFG_DATA_BITS'(w);
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      board.set_register(reg_ids[i], vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic run_traffic(input int count, input int reach);
    int pick;
    logic md;
    logic [QUEUE_BITS-1:0] q;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) wall_ms = $urandom;
      else if (pick < 6) wall_ms = wall_ms + $urandom_range(0, 100000);
      else wall_ms = wall_ms + $urandom_range(0, 30);
      md = ($urandom_range(0, 2) == 0) ? MODE_NOTICE : MODE_ARRIVAL;
      pick = $urandom_range(0, 99);
      if (pick < 20) q = '0;
      else if (pick < 30) q = QUEUE_BITS'($urandom);
      else q = QUEUE_BITS'($urandom_range(0, reach));
      send_request(md, wall_ms, q, FRAC_BITS'($urandom), $urandom);
    end
  endtask

  task automatic random_phase(input phase_kind_t kind, input bit squeeze);
    logic [QUEUE_BITS-1:0] lo_th, hi_th;
    logic [PROB_BITS-1:0]  pl, ph, w;
    int reach;
    lo_th = QUEUE_BITS'($urandom_range(1, 40));
    hi_th = lo_th + QUEUE_BITS'($urandom_range(1, 200));
    pl = PROB_BITS'($urandom_range(0, 16384));
    ph = PROB_BITS'($urandom_range(pl, 65536));
    w  = PROB_BITS'($urandom_range(1, 65536));
    case (kind)
      PH_FALLING: begin
        pl = PROB_BITS'($urandom_range(32768, 65536));
        ph = PROB_BITS'($urandom_range(0, pl));
      end
      PH_CROSSED: hi_th = QUEUE_BITS'($urandom_range(0, lo_th - 1));
      PH_EQUAL: begin
        hi_th = lo_th;
        w = ONE_FX;
      end
      PH_FULL_SPAN: begin
        lo_th = '0;
        hi_th = '1;
        pl = '0;
        ph = ONE_FX;
        w = ONE_FX;
      end
      PH_OVERSIZED: begin
        pl = PROB_BITS'($urandom_range(65536, 131071));
        ph = PROB_BITS'($urandom_range(65536, 131071));
      end
      PH_SLOW_WEIGHT: w = PROB_BITS'($urandom_range(1, 64));
      PH_HIGH_QUEUE: begin
        lo_th = QUEUE_BITS'($urandom_range(1000, 900000));
        hi_th = lo_th + QUEUE_BITS'($urandom_range(1, 100000));
      end
      default: ;
    endcase
    reach = ((lo_th > hi_th) ? int'(lo_th) : int'(hi_th)) + int'(hi_th) / 4 + 16;
    if (reach > 1048575) reach = 1048575;
    wait_for_verdicts();
    write_config(lo_th, hi_th, pl, ph, w);
    tx_idle_on = (kind == PH_EQUAL) ? 1'b0 : ($urandom_range(0, 3) != 0);
    rx_idle_on = (kind == PH_EQUAL) ? 1'b0 : ($urandom_range(0, 3) != 0);
    if (squeeze) begin
      long_hold_req = 1'b1;
      run_traffic(PHASE_ITEMS / 2, reach);
      wait_for_verdicts();
      run_traffic(PHASE_ITEMS - PHASE_ITEMS / 2, reach);
    end else begin
      run_traffic(PHASE_ITEMS, reach);
    end
  endtask

  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = rx_idle_on ? $urandom_range(0, 4) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      board.check_verdict(verdict, tag_out, probability_out, average_out, drops_so_far);
    end
  end

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_config(20'd100, 20'd200, 17'd1000, 17'd60000, ONE_FX);
    send_request(MODE_ARRIVAL, 32'd0, QUEUE_BITS'($urandom), 16'd0, $urandom);
    send_request(MODE_NOTICE, 32'd5, 20'd100, FRAC_BITS'($urandom), $urandom);
    send_request(MODE_ARRIVAL, 32'd6, QUEUE_BITS'($urandom), 16'd1000, $urandom);
    send_request(MODE_ARRIVAL, 32'd7, QUEUE_BITS'($urandom), 16'd999, $urandom);
    send_request(MODE_NOTICE, 32'd8, 20'd200, FRAC_BITS'($urandom), $urandom);
    send_request(MODE_ARRIVAL, 32'd9, QUEUE_BITS'($urandom), 16'd59999, $urandom);
    send_request(MODE_ARRIVAL, 32'd9, QUEUE_BITS'($urandom), 16'd60000, $urandom);
    send_request(MODE_NOTICE, 32'd10, 20'd150, FRAC_BITS'($urandom), $urandom);
    send_request(MODE_ARRIVAL, 32'd11, QUEUE_BITS'($urandom), 16'd30499, $urandom);
    send_request(MODE_NOTICE, 32'd12, 20'hFFFFF, FRAC_BITS'($urandom), $urandom);
    send_request(MODE_ARRIVAL, 32'd13, QUEUE_BITS'($urandom), 16'hFFFF, 32'h0000_0000);
    send_request(MODE_NOTICE, 32'd1000, 20'd0, FRAC_BITS'($urandom), $urandom);
    send_request(MODE_ARRIVAL, 32'd1000, QUEUE_BITS'($urandom), FRAC_BITS'($urandom),
                 $urandom);
    send_request(MODE_ARRIVAL, 32'd1003, QUEUE_BITS'($urandom), FRAC_BITS'($urandom),
                 $urandom);
    wait_for_verdicts();

    write_config(20'hFFFFF, 20'd0, 17'h1FFFF, 17'h1FFFF, 17'd0);
    send_request(MODE_ARRIVAL, 32'hFFFF_FFFF, QUEUE_BITS'($urandom), 16'hFFFF, 32'hFFFF_FFFF);
    wait_for_verdicts();

    write_config(20'd0, 20'hFFFFF, 17'd0, ONE_FX, 17'd1);
    send_request(MODE_NOTICE, 32'd20, 20'hFFFFF, FRAC_BITS'($urandom), $urandom);
    send_request(MODE_ARRIVAL, 32'd21, QUEUE_BITS'($urandom), FRAC_BITS'($urandom),
                 $urandom);
    send_request(MODE_NOTICE, 32'hFFFF_FFF0, 20'd0, FRAC_BITS'($urandom), $urandom);
    send_request(MODE_ARRIVAL, 32'h0000_0010, QUEUE_BITS'($urandom), FRAC_BITS'($urandom),
                 $urandom);
    send_request(MODE_ARRIVAL, 32'h0002_0000, QUEUE_BITS'($urandom), FRAC_BITS'($urandom),
                 $urandom);
    wait_for_verdicts();

    write_config(20'd50, 20'd50, 17'd20000, 17'd40000, ONE_FX);
    send_request(MODE_NOTICE, 32'd30, 20'd50, FRAC_BITS'($urandom), $urandom);
    send_request(MODE_ARRIVAL, 32'd31, QUEUE_BITS'($urandom), FRAC_BITS'($urandom),
                 $urandom);
    send_request(MODE_NOTICE, 32'd32, 20'd49, FRAC_BITS'($urandom), $urandom);
    send_request(MODE_ARRIVAL, 32'd33, QUEUE_BITS'($urandom), FRAC_BITS'($urandom),
                 $urandom);
    send_request(MODE_NOTICE, 32'd34, 20'd51, FRAC_BITS'($urandom), $urandom);
    send_request(MODE_ARRIVAL, 32'd35, QUEUE_BITS'($urandom), FRAC_BITS'($urandom),
                 $urandom);

    random_phase(PH_RISING, 1'b0);
    random_phase(PH_RISING, 1'b1);
    random_phase(PH_FALLING, 1'b0);
    random_phase(PH_CROSSED, 1'b0);
    random_phase(PH_EQUAL, 1'b0);
    random_phase(PH_FULL_SPAN, 1'b0);
    random_phase(PH_OVERSIZED, 1'b0);
    random_phase(PH_SLOW_WEIGHT, 1'b0);
    random_phase(PH_HIGH_QUEUE, 1'b0);
    wait_for_verdicts();

    if (board.passed()) begin
      $display("** red_queue_drop_decider: PASSED **");
    end else begin
      $display("** red_queue_drop_decider: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
